/* rtl/core/prac_pkg.sv */
package prac_pkg;

    // Coordinate and angle formats.
    localparam int COORD_BITS    = 32;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int ANGLE_BITS    = 16;
    localparam int FOLD_BITS     = 14;
    localparam int MAG_BITS      = FOLD_BITS - 1;

    // CORDIC datapath: x and y in Q2.30, z in units of 2^-32 turn.
    localparam int CORDIC_STAGES = 18;
    localparam int TRIG_BITS     = 32;
    localparam int Z_BITS        = 32;

    // Degrees times 64 to turn units: z = e * 2^23 / 45, done as a multiply by
    // ceil(2^42 / 45) and a shift by 19, exact for |e| up to a quarter turn.
    localparam int RECIP_BITS    = 37;
    localparam int RECIP_SHIFT   = 19;
    localparam int QPROD_BITS    = MAG_BITS + RECIP_BITS;
    localparam int Q_BITS        = QPROD_BITS - RECIP_SHIFT;
    localparam logic [RECIP_BITS-1:0] RECIP_MULT = 37'd97734366914;

    // Stream packing.
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + ANGLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    localparam logic signed [ANGLE_BITS:0] ANGLE_LIMIT  = 17'sd23040;
    localparam logic signed [ANGLE_BITS:0] HALF_TURN    = 17'sd11520;
    localparam logic signed [ANGLE_BITS:0] FULL_TURN    = 17'sd23040;
    localparam logic signed [ANGLE_BITS:0] QUARTER_TURN = 17'sd5760;

    localparam logic signed [TRIG_BITS-1:0] CORDIC_X0 = 32'sd652032874;
    localparam logic signed [TRIG_BITS-1:0] TRIG_ONE  = 32'sh4000_0000;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // Fields that travel alongside the angle through the CORDIC.
    typedef struct packed {
        logic                          neg;
        logic signed [DIFF_BITS-1:0]   dx;
        logic signed [DIFF_BITS-1:0]   dy;
        logic signed [COORD_BITS-1:0]  cx;
        logic signed [COORD_BITS-1:0]  cy;
    } side_t;

    typedef struct packed {
        logic                          sat;
        logic signed [COORD_BITS-1:0]  y;
        logic signed [COORD_BITS-1:0]  x;
    } result_t;

    // atan(2^-i) in units of 2^-32 turn.
    function automatic logic signed [Z_BITS-1:0] atan_entry(input int idx);
        logic signed [Z_BITS-1:0] v;
        case (idx)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41721;
            15:      v = 32'sd20860;
            16:      v = 32'sd10430;
            17:      v = 32'sd5215;
            18:      v = 32'sd2607;
            19:      v = 32'sd1303;
            20:      v = 32'sd651;
            21:      v = 32'sd325;
            22:      v = 32'sd162;
            23:      v = 32'sd81;
            24:      v = 32'sd40;
            25:      v = 32'sd20;
            26:      v = 32'sd10;
            27:      v = 32'sd5;
            28:      v = 32'sd2;
            29:      v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/prac_angle_prep.sv */
module prac_angle_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic                                   mode,
    input  logic signed [prac_pkg::COORD_BITS-1:0] point_x,
    input  logic signed [prac_pkg::COORD_BITS-1:0] point_y,
    input  logic signed [prac_pkg::COORD_BITS-1:0] center_x,
    input  logic signed [prac_pkg::COORD_BITS-1:0] center_y,
    input  logic signed [prac_pkg::ANGLE_BITS-1:0] angle_deg,
    output logic                                   out_valid,
    output logic signed [prac_pkg::Z_BITS-1:0]     z,
    output prac_pkg::side_t                        side
);

    logic signed [prac_pkg::ANGLE_BITS:0]    ang_clamp;
    logic signed [prac_pkg::ANGLE_BITS:0]    ang_dir;
    logic signed [prac_pkg::ANGLE_BITS:0]    ang_wrap;
    logic signed [prac_pkg::ANGLE_BITS:0]    ang_fold;
    logic signed [prac_pkg::COORD_BITS-1:0]  cx_sel;
    logic signed [prac_pkg::COORD_BITS-1:0]  cy_sel;
    prac_pkg::side_t                         side_next;
    logic signed [prac_pkg::FOLD_BITS-1:0]   e_next;
    logic [prac_pkg::MAG_BITS-1:0]           mag;
    logic [prac_pkg::QPROD_BITS-1:0]         qprod;
    logic [prac_pkg::Q_BITS-1:0]             q_next;
    logic signed [prac_pkg::Z_BITS-1:0]      z_next;

    logic                                    valid_a_reg;
    logic                                    valid_b_reg;
    logic                                    valid_c_reg;
    logic signed [prac_pkg::FOLD_BITS-1:0]   e_a_reg;
    prac_pkg::side_t                         side_a_reg;
    logic [prac_pkg::Q_BITS-1:0]             q_b_reg;
    logic                                    zneg_b_reg;
    prac_pkg::side_t                         side_b_reg;
    logic signed [prac_pkg::Z_BITS-1:0]      z_c_reg;
    prac_pkg::side_t                         side_c_reg;

    // Stage A: clamp, direction, wrap to a half turn each way, then fold into
    // a quarter turn each way; the fold flips the sign of cos and sin.
    always_comb
    begin
        ang_clamp = (prac_pkg::ANGLE_BITS+1)'(angle_deg);
        if (ang_clamp > prac_pkg::ANGLE_LIMIT)
        begin
            ang_clamp = prac_pkg::ANGLE_LIMIT;
        end
        else if (ang_clamp < -prac_pkg::ANGLE_LIMIT)
        begin
            ang_clamp = -prac_pkg::ANGLE_LIMIT;
        end

        ang_dir = mode ? -ang_clamp : ang_clamp;

        ang_wrap = ang_dir;
        if (ang_dir > prac_pkg::HALF_TURN)
        begin
            ang_wrap = ang_dir - prac_pkg::FULL_TURN;
        end
        else if (ang_dir < -prac_pkg::HALF_TURN)
        begin
            ang_wrap = ang_dir + prac_pkg::FULL_TURN;
        end

        ang_fold       = ang_wrap;
        side_next.neg  = 1'b0;
        if (ang_wrap > prac_pkg::QUARTER_TURN)
        begin
            ang_fold      = ang_wrap - prac_pkg::HALF_TURN;
            side_next.neg = 1'b1;
        end
        else if (ang_wrap < -prac_pkg::QUARTER_TURN)
        begin
            ang_fold      = ang_wrap + prac_pkg::HALF_TURN;
            side_next.neg = 1'b1;
        end
        e_next = ang_fold[prac_pkg::FOLD_BITS-1:0];

        // Clockwise mode rotates about the origin.
        cx_sel       = mode ? '0 : center_x;
        cy_sel       = mode ? '0 : center_y;
        side_next.cx = cx_sel;
        side_next.cy = cy_sel;
        side_next.dx = prac_pkg::DIFF_BITS'(point_x) - prac_pkg::DIFF_BITS'(cx_sel);
        side_next.dy = prac_pkg::DIFF_BITS'(point_y) - prac_pkg::DIFF_BITS'(cy_sel);
    end

    // Stage B: magnitude times the reciprocal of 45.
    always_comb
    begin
        mag    = e_a_reg[prac_pkg::FOLD_BITS-1] ? prac_pkg::MAG_BITS'(-e_a_reg)
                                                : prac_pkg::MAG_BITS'(e_a_reg);
        qprod  = prac_pkg::QPROD_BITS'(mag) * prac_pkg::QPROD_BITS'(prac_pkg::RECIP_MULT);
        q_next = qprod[prac_pkg::QPROD_BITS-1:prac_pkg::RECIP_SHIFT];
    end

    // Stage C: the quotient truncates toward zero, so the sign goes on last.
    assign z_next = zneg_b_reg ? -prac_pkg::Z_BITS'(q_b_reg) : prac_pkg::Z_BITS'(q_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_a_reg    <= e_next;
            side_a_reg <= side_next;
            q_b_reg    <= q_next;
            zneg_b_reg <= e_a_reg[prac_pkg::FOLD_BITS-1];
            side_b_reg <= side_a_reg;
            z_c_reg    <= z_next;
            side_c_reg <= side_b_reg;
        end
    end

    assign out_valid = valid_c_reg;
    assign z         = z_c_reg;
    assign side      = side_c_reg;

endmodule

/* rtl/core/prac_cordic.sv */
module prac_cordic (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [prac_pkg::Z_BITS-1:0]    z,
    input  prac_pkg::side_t                       side_in,
    output logic                                  out_valid,
    output logic signed [prac_pkg::TRIG_BITS-1:0] cos_val,
    output logic signed [prac_pkg::TRIG_BITS-1:0] sin_val,
    output prac_pkg::side_t                       side_out
);

    localparam int N = prac_pkg::CORDIC_STAGES;

    logic [N-1:0]                            valid_reg;
    logic signed [prac_pkg::TRIG_BITS-1:0]   x_reg    [N];
    logic signed [prac_pkg::TRIG_BITS-1:0]   y_reg    [N];
    logic signed [prac_pkg::Z_BITS-1:0]      z_reg    [N-1];
    prac_pkg::side_t                         side_reg [N];

    logic signed [prac_pkg::TRIG_BITS-1:0]   cos_next;
    logic signed [prac_pkg::TRIG_BITS-1:0]   sin_next;
    logic                                    valid_out_reg;
    logic signed [prac_pkg::TRIG_BITS-1:0]   cos_reg;
    logic signed [prac_pkg::TRIG_BITS-1:0]   sin_reg;
    prac_pkg::side_t                         side_out_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic signed [prac_pkg::TRIG_BITS-1:0] x_in;
        logic signed [prac_pkg::TRIG_BITS-1:0] y_in;
        logic signed [prac_pkg::Z_BITS-1:0]    z_in;
        prac_pkg::side_t                       s_in;
        logic                                  up;
        logic signed [prac_pkg::TRIG_BITS-1:0] xs;
        logic signed [prac_pkg::TRIG_BITS-1:0] ys;

        if (i == 0)
        begin : g_first
            assign x_in = prac_pkg::CORDIC_X0;
            assign y_in = '0;
            assign z_in = z;
            assign s_in = side_in;
        end
        else
        begin : g_next
            assign x_in = x_reg[i-1];
            assign y_in = y_reg[i-1];
            assign z_in = z_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        // Turn toward zero residual angle; both shifts use the stage inputs.
        assign up = ~z_in[prac_pkg::Z_BITS-1];
        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= up ? x_in - ys : x_in + ys;
                y_reg[i]    <= up ? y_in + xs : y_in - xs;
                side_reg[i] <= s_in;
            end
        end

        if (i < N - 1)
        begin : g_angle
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    z_reg[i] <= up ? z_in - prac_pkg::atan_entry(i)
                                   : z_in + prac_pkg::atan_entry(i);
                end
            end
        end
    end

    // Undo the quadrant fold and keep both values within plus and minus one.
    always_comb
    begin
        cos_next = side_reg[N-1].neg ? -x_reg[N-1] : x_reg[N-1];
        sin_next = side_reg[N-1].neg ? -y_reg[N-1] : y_reg[N-1];
        if (cos_next > prac_pkg::TRIG_ONE)
        begin
            cos_next = prac_pkg::TRIG_ONE;
        end
        else if (cos_next < -prac_pkg::TRIG_ONE)
        begin
            cos_next = -prac_pkg::TRIG_ONE;
        end
        if (sin_next > prac_pkg::TRIG_ONE)
        begin
            sin_next = prac_pkg::TRIG_ONE;
        end
        else if (sin_next < -prac_pkg::TRIG_ONE)
        begin
            sin_next = -prac_pkg::TRIG_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            valid_out_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[N-2:0], in_valid};
            valid_out_reg <= valid_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg      <= cos_next;
            sin_reg      <= sin_next;
            side_out_reg <= side_reg[N-1];
        end
    end

    assign out_valid = valid_out_reg;
    assign cos_val   = cos_reg;
    assign sin_val   = sin_reg;
    assign side_out  = side_out_reg;

endmodule

/* rtl/core/prac_apply.sv */
module prac_apply (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [prac_pkg::TRIG_BITS-1:0] cos_val,
    input  logic signed [prac_pkg::TRIG_BITS-1:0] sin_val,
    input  prac_pkg::side_t                       side,
    output logic                                  out_valid,
    output prac_pkg::result_t                     result
);

    localparam int PROD_BITS = prac_pkg::DIFF_BITS + prac_pkg::TRIG_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int FRAC_BITS = prac_pkg::TRIG_BITS - 2;
    localparam int ROT_BITS  = SUM_BITS - FRAC_BITS;
    localparam int OUT_BITS  = ROT_BITS + 1;
    localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [OUT_BITS-1:0] OUT_MAX = OUT_BITS'(prac_pkg::COORD_MAX);
    localparam logic signed [OUT_BITS-1:0] OUT_MIN = OUT_BITS'(prac_pkg::COORD_MIN);

    logic                                    valid_e_reg;
    logic                                    valid_f_reg;
    logic                                    valid_g_reg;
    logic signed [PROD_BITS-1:0]             dxc_reg;
    logic signed [PROD_BITS-1:0]             dys_reg;
    logic signed [PROD_BITS-1:0]             dxs_reg;
    logic signed [PROD_BITS-1:0]             dyc_reg;
    logic signed [prac_pkg::COORD_BITS-1:0]  cx_e_reg;
    logic signed [prac_pkg::COORD_BITS-1:0]  cy_e_reg;
    logic signed [SUM_BITS-1:0]              sum_x;
    logic signed [SUM_BITS-1:0]              sum_y;
    logic signed [ROT_BITS-1:0]              rx_reg;
    logic signed [ROT_BITS-1:0]              ry_reg;
    logic signed [prac_pkg::COORD_BITS-1:0]  cx_f_reg;
    logic signed [prac_pkg::COORD_BITS-1:0]  cy_f_reg;
    logic signed [OUT_BITS-1:0]              tx;
    logic signed [OUT_BITS-1:0]              ty;
    prac_pkg::result_t                       result_next;
    prac_pkg::result_t                       result_reg;

    // Stage F: exact dot products with round-half-up, then floor by 2^30.
    assign sum_x = SUM_BITS'(dxc_reg) - SUM_BITS'(dys_reg) + ROUND_HALF;
    assign sum_y = SUM_BITS'(dxs_reg) + SUM_BITS'(dyc_reg) + ROUND_HALF;

    // Stage G: translate back and saturate.
    always_comb
    begin
        tx              = OUT_BITS'(rx_reg) + OUT_BITS'(cx_f_reg);
        ty              = OUT_BITS'(ry_reg) + OUT_BITS'(cy_f_reg);
        result_next.sat = 1'b0;
        result_next.x   = tx[prac_pkg::COORD_BITS-1:0];
        result_next.y   = ty[prac_pkg::COORD_BITS-1:0];
        if (tx > OUT_MAX)
        begin
            result_next.x   = prac_pkg::COORD_MAX;
            result_next.sat = 1'b1;
        end
        else if (tx < OUT_MIN)
        begin
            result_next.x   = prac_pkg::COORD_MIN;
            result_next.sat = 1'b1;
        end
        if (ty > OUT_MAX)
        begin
            result_next.y   = prac_pkg::COORD_MAX;
            result_next.sat = 1'b1;
        end
        else if (ty < OUT_MIN)
        begin
            result_next.y   = prac_pkg::COORD_MIN;
            result_next.sat = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_e_reg <= 1'b0;
            valid_f_reg <= 1'b0;
            valid_g_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_e_reg <= in_valid;
            valid_f_reg <= valid_e_reg;
            valid_g_reg <= valid_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dxc_reg    <= PROD_BITS'(side.dx) * PROD_BITS'(cos_val);
            dys_reg    <= PROD_BITS'(side.dy) * PROD_BITS'(sin_val);
            dxs_reg    <= PROD_BITS'(side.dx) * PROD_BITS'(sin_val);
            dyc_reg    <= PROD_BITS'(side.dy) * PROD_BITS'(cos_val);
            cx_e_reg   <= side.cx;
            cy_e_reg   <= side.cy;
            rx_reg     <= sum_x[SUM_BITS-1:FRAC_BITS];
            ry_reg     <= sum_y[SUM_BITS-1:FRAC_BITS];
            cx_f_reg   <= cx_e_reg;
            cy_f_reg   <= cy_e_reg;
            result_reg <= result_next;
        end
    end

    assign out_valid = valid_g_reg;
    assign result    = result_reg;

endmodule

/* rtl/core/point_rotate_about_center.sv */
// Rotates a Q16.16 point by a signed angle in 1/64 degree: with tuser 0 it turns
// counter-clockwise about the given center, with tuser 1 clockwise about the
// origin (center ignored). One request is taken every clock cycle while
// s_axis_tready is high. A result passes through angle preparation, the
// pipelined CORDIC that runs one micro-rotation per stage, the multiply and
// sum stages, and the output register. A two-entry output buffer lets the
// block take one more request while a result waits, and tready drops only
// when that buffer is full. Results saturate to the signed 32-bit range and
// m_axis_tuser flags a clamped coordinate.
module point_rotate_about_center (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // point_x, point_y, center_x, center_y, angle_deg
    input  logic [prac_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
    // mode
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_x, out_y
    output logic [prac_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
    // saturated
    output logic                                   m_axis_tuser
);

    localparam int CB = prac_pkg::COORD_BITS;

    logic                                   pipe_en;
    logic                                   in_fire;
    logic signed [CB-1:0]                   point_x;
    logic signed [CB-1:0]                   point_y;
    logic signed [CB-1:0]                   center_x;
    logic signed [CB-1:0]                   center_y;
    logic signed [prac_pkg::ANGLE_BITS-1:0] angle_deg;

    logic                                   prep_valid;
    logic signed [prac_pkg::Z_BITS-1:0]     prep_z;
    prac_pkg::side_t                        prep_side;
    logic                                   cord_valid;
    logic signed [prac_pkg::TRIG_BITS-1:0]  cord_cos;
    logic signed [prac_pkg::TRIG_BITS-1:0]  cord_sin;
    prac_pkg::side_t                        cord_side;
    logic                                   pipe_valid;
    prac_pkg::result_t                      pipe_result;
    logic                                   pipe_push;

    logic                                   out_valid_reg;
    prac_pkg::result_t                      out_reg;
    logic                                   skid_valid_reg;
    prac_pkg::result_t                      skid_reg;

    assign point_x   = s_axis_tdata[0*CB +: CB];
    assign point_y   = s_axis_tdata[1*CB +: CB];
    assign center_x  = s_axis_tdata[2*CB +: CB];
    assign center_y  = s_axis_tdata[3*CB +: CB];
    assign angle_deg = s_axis_tdata[4*CB +: prac_pkg::ANGLE_BITS];

    // The whole pipeline moves as one until the output buffer fills.
    assign pipe_en       = ~skid_valid_reg;
    assign s_axis_tready = pipe_en;
    assign in_fire       = s_axis_tvalid & pipe_en;
    assign pipe_push     = pipe_en & pipe_valid;

    prac_angle_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (in_fire),
        .mode      (s_axis_tuser),
        .point_x   (point_x),
        .point_y   (point_y),
        .center_x  (center_x),
        .center_y  (center_y),
        .angle_deg (angle_deg),
        .out_valid (prep_valid),
        .z         (prep_z),
        .side      (prep_side)
    );

    prac_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (prep_valid),
        .z         (prep_z),
        .side_in   (prep_side),
        .out_valid (cord_valid),
        .cos_val   (cord_cos),
        .sin_val   (cord_sin),
        .side_out  (cord_side)
    );

    prac_apply u_apply (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (cord_valid),
        .cos_val   (cord_cos),
        .sin_val   (cord_sin),
        .side      (cord_side),
        .out_valid (pipe_valid),
        .result    (pipe_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_push;
            end
        end
        else if (pipe_push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : pipe_result;
        end
        else if (pipe_push)
        begin
            skid_reg <= pipe_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = prac_pkg::OUT_DATA_BITS'({out_reg.y, out_reg.x});
    assign m_axis_tuser  = out_reg.sat;

    // The buffer entry is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("output buffer holds a result while the output is empty");

    a_stalled_push_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready && pipe_push) |=> skid_valid_reg)
        else $error("result leaving the pipeline during a stall was dropped");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.sat) |->
            (out_reg.x == prac_pkg::COORD_MAX || out_reg.x == prac_pkg::COORD_MIN ||
             out_reg.y == prac_pkg::COORD_MAX || out_reg.y == prac_pkg::COORD_MIN))
        else $error("saturation flagged with neither coordinate at a limit");

endmodule
